@@ hw/rtl/mbd_pkg.sv @@
package mbd_pkg;

  localparam logic [7:0] FlagByte    = 8'hF9;
  localparam logic [7:0] CrcPreset   = 8'hFF;
  localparam logic [7:0] CrcGood     = 8'hCF;
  localparam logic [7:0] CrcPolyRefl = 8'hE0;
  localparam logic [7:0] PfClearMask = 8'hEF;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_FCS_ERR = 2'd2,
    KIND_NO_FLAG = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [5:0]  channel;
    logic [7:0]  control_field;
    logic [14:0] info_length;
    logic        frame_end;
  } res_t;

  // reflected CRC-8, poly 0x07
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/mbd_if.sv @@
interface mbd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mbd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [5:0]  channel;
  logic [7:0]  control_field;
  logic [14:0] info_length;
  logic        frame_end;

  modport source (
    output valid, output kind, output data_byte, output channel,
    output control_field, output info_length, output frame_end, input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input channel,
    input control_field, input info_length, input frame_end, output ready
  );
endinterface

@@ hw/rtl/mbd_core.sv @@
module mbd_core import mbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_ADDR, PH_CTRL, PH_LEN1, PH_LEN2, PH_INFO, PH_FCS, PH_CLOSE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  crc_q, crc_d;
  logic [5:0]  chan_q, chan_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [14:0] len_q, len_d;
  logic [14:0] rem_q, rem_d;
  logic        fcs_ok_q, fcs_ok_d;
  logic [7:0]  crc_nx;
  logic        is_flag;

  assign is_flag = (rx_byte_i == FlagByte);
  assign crc_nx  = crc_step((phase_q == PH_ADDR) ? CrcPreset : crc_q, rx_byte_i);

  always_comb begin
    phase_d     = phase_q;
    crc_d       = crc_q;
    chan_d      = chan_q;
    ctrl_d      = ctrl_q;
    len_d       = len_q;
    rem_d       = rem_q;
    fcs_ok_d    = fcs_ok_q;
    res_valid_o = 1'b0;
    res_o.kind          = KIND_PAYLOAD;
    res_o.data_byte     = 8'h00;
    res_o.channel       = chan_q;
    res_o.control_field = ctrl_q;
    res_o.info_length   = len_q;
    res_o.frame_end     = 1'b0;
    case (phase_q)
      PH_HUNT: begin
        if (is_flag) phase_d = PH_ADDR;
      end
      PH_ADDR: begin
        if (!is_flag) begin
          if (!rx_byte_i[0]) begin
            phase_d = PH_HUNT;
          end else begin
            chan_d  = rx_byte_i[7:2];
            crc_d   = crc_nx;
            phase_d = PH_CTRL;
          end
        end
      end
      PH_CTRL: begin
        ctrl_d  = rx_byte_i & PfClearMask;
        crc_d   = crc_nx;
        phase_d = PH_LEN1;
      end
      PH_LEN1: begin
        len_d = {8'h00, rx_byte_i[7:1]};
        crc_d = crc_nx;
        if (rx_byte_i[0]) begin
          rem_d   = {8'h00, rx_byte_i[7:1]};
          phase_d = (rx_byte_i[7:1] != 7'd0) ? PH_INFO : PH_FCS;
        end else begin
          phase_d = PH_LEN2;
        end
      end
      PH_LEN2: begin
        len_d   = {rx_byte_i, len_q[6:0]};
        crc_d   = crc_nx;
        rem_d   = {rx_byte_i, len_q[6:0]};
        phase_d = ({rx_byte_i, len_q[6:0]} != 15'd0) ? PH_INFO : PH_FCS;
      end
      PH_INFO: begin
        res_valid_o     = 1'b1;
        res_o.data_byte = rx_byte_i;
        rem_d           = rem_q - 15'd1;
        if (rem_q == 15'd1) phase_d = PH_FCS;
      end
      PH_FCS: begin
        fcs_ok_d = (crc_nx == CrcGood);
        phase_d  = PH_CLOSE;
      end
      PH_CLOSE: begin
        res_valid_o     = 1'b1;
        res_o.frame_end = 1'b1;
        if (!fcs_ok_q)    res_o.kind = KIND_FCS_ERR;
        else if (is_flag) res_o.kind = KIND_GOOD;
        else              res_o.kind = KIND_NO_FLAG;
        phase_d = is_flag ? PH_ADDR : PH_HUNT;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      crc_q    <= CrcPreset;
      chan_q   <= '0;
      ctrl_q   <= '0;
      len_q    <= '0;
      rem_q    <= '0;
      fcs_ok_q <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      chan_q   <= chan_d;
      ctrl_q   <= ctrl_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      fcs_ok_q <= fcs_ok_d;
    end
  end

`ifndef SYNTHESIS
  a_info_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_INFO |-> rem_q != 15'd0)
    else $error("info phase with zero remaining count");
  a_rem_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_INFO |-> rem_q <= len_q)
    else $error("remaining count exceeds length");
  a_close_after_fcs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CLOSE |-> $past(phase_q) == PH_FCS || $past(phase_q) == PH_CLOSE)
    else $error("close phase not preceded by fcs");
`endif

endmodule

@@ hw/rtl/mux_basic_deframer.sv @@
// channel  dir  request payload
// rx_i     in   rx_byte[7:0]
// res_o    out  kind[1:0] data_byte[7:0] channel[5:0] control_field[7:0]
//              info_length[14:0] frame_end
//
// One byte per cycle while rx_i.ready is high; a result the frame parser
// yields for a byte is registered and shows in the cycle after it is taken.
// rx_i.ready is low only while a held result is not taken (res_o stalled).
// Reset puts the parser in flag hunt with the CRC preset loaded.
module mux_basic_deframer import mbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mbd_rx_if.sink    rx_i,
  mbd_res_if.source res_o
);

  logic accept;
  logic core_valid;
  res_t core_res;
  logic out_valid_q;
  res_t out_q;

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  mbd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_i.rx_byte),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      out_valid_q <= accept && core_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && core_valid) out_q <= core_res;
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.kind          = out_q.kind;
  assign res_o.data_byte     = out_q.data_byte;
  assign res_o.channel       = out_q.channel;
  assign res_o.control_field = out_q.control_field;
  assign res_o.info_length   = out_q.info_length;
  assign res_o.frame_end     = out_q.frame_end;

`ifndef SYNTHESIS
  a_end_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.frame_end == (res_o.kind != KIND_PAYLOAD))
    else $error("frame_end inconsistent with kind");
  a_verdict_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.frame_end |-> res_o.data_byte == 8'h00)
    else $error("verdict carries data");
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_i.ready == (!res_o.valid || res_o.ready))
    else $error("input ready mismatch");
`endif

endmodule
